FILE: rtl/core/lcdt_pkg.sv
// lcdt_pkg: shared types, timing constants, mode and register codes
// for the display mode timing sequencer. No dependencies.
package lcdt_pkg;

    // widths of the fields and state
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned LINE_W   = 8;
    localparam int unsigned DOT_W    = 10;
    localparam int unsigned TICK_W   = 8;
    localparam int unsigned CFG_A_W  = 3;
    localparam int unsigned CFG_D_W  = 8;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

    // dot counts per mode and line limits
    localparam logic [DOT_W-1:0]  OAM_DOTS     = 10'd80;
    localparam logic [DOT_W-1:0]  XFER_DOTS    = 10'd172;
    localparam logic [DOT_W-1:0]  HBLANK_DOTS  = 10'd204;
    localparam logic [DOT_W-1:0]  LINE_DOTS    = 10'd456;
    localparam logic [LINE_W-1:0] FIRST_VBLANK = 8'd144;
    localparam logic [LINE_W-1:0] LAST_LINE    = 8'd153;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_COMPARE_LINE = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_DISPLAY_EN   = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_HBLANK_IE    = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_VBLANK_IE    = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_OAM_IE       = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_COINC_IE     = 3'd5;

    // configuration seen by the step logic
    typedef struct packed {
        logic [LINE_W-1:0] compare_line;
        logic              display_enable;
        logic              hblank_irq_enable;
        logic              vblank_stat_enable;
        logic              oam_irq_enable;
        logic              coincidence_irq_enable;
    } t_cfg;

    // timing state carried between items
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LINE_W-1:0] line;
        logic [DOT_W-1:0]  dots;
        logic              coinc;
    } t_state;

    // one result item
    typedef struct packed {
        logic [MODE_W-1:0] mode_now;
        logic [LINE_W-1:0] line_now;
        logic              coincidence;
        logic              stat_irq;
        logic              vblank_irq;
        logic              frame_done;
        logic              render_line;
        logic [LINE_W-1:0] rendered_index;
    } t_result;

endpackage

FILE: rtl/core/lcdt_step.sv
// lcdt_step: next timing state and result for one item of elapsed ticks.
// Purely combinational; depends on lcdt_pkg.
module lcdt_step
    import lcdt_pkg::*;
(
    input  t_state            i_state,
    input  t_cfg              i_cfg,
    input  logic [TICK_W-1:0] i_tick_count,
    output t_state            o_state,
    output t_result           o_result
);

    logic [DOT_W:0]    dot_sum;
    logic [DOT_W-1:0]  dots;
    logic [LINE_W-1:0] line_inc;
    logic              coinc_inc;
    logic              coinc_zero;
    t_state            nxt;
    t_result           res;

    // dot accumulation, saturated at the counter's full scale
    assign dot_sum  = {1'b0, i_state.dots} + {{(DOT_W+1-TICK_W){1'b0}}, i_tick_count};
    assign dots     = dot_sum[DOT_W] ? {DOT_W{1'b1}} : dot_sum[DOT_W-1:0];
    assign line_inc = i_state.line + 8'd1;
    assign coinc_inc  = (line_inc == i_cfg.compare_line);
    assign coinc_zero = (i_cfg.compare_line == '0);

    // mode sequencing, at most one change per item
    always_comb begin
        nxt      = i_state;
        nxt.dots = dots;
        res      = '0;
        unique case (i_state.mode)
            MODE_OAM: begin
                if (dots >= OAM_DOTS) begin
                    nxt.mode = MODE_XFER;
                    nxt.dots = '0;
                end
            end
            MODE_XFER: begin
                if (dots >= XFER_DOTS) begin
                    nxt.mode           = MODE_HBLANK;
                    nxt.dots           = '0;
                    res.stat_irq       = i_cfg.display_enable & i_cfg.hblank_irq_enable;
                    res.render_line    = 1'b1;
                    res.rendered_index = i_state.line;
                end
            end
            MODE_HBLANK: begin
                if (dots >= HBLANK_DOTS) begin
                    nxt.line  = line_inc;
                    nxt.coinc = coinc_inc;
                    nxt.dots  = '0;
                    res.stat_irq = coinc_inc & i_cfg.display_enable
                                 & i_cfg.coincidence_irq_enable;
                    if (line_inc >= FIRST_VBLANK) begin
                        nxt.mode = MODE_VBLANK;
                        if (i_cfg.display_enable
                            && (i_cfg.vblank_stat_enable || i_cfg.oam_irq_enable)) begin
                            res.stat_irq = 1'b1;
                        end
                        res.vblank_irq = i_cfg.display_enable;
                        res.frame_done = i_cfg.display_enable;
                    end else begin
                        nxt.mode = MODE_OAM;
                        if (i_cfg.display_enable && i_cfg.oam_irq_enable) begin
                            res.stat_irq = 1'b1;
                        end
                    end
                end
            end
            MODE_VBLANK: begin
                if (dots >= LINE_DOTS) begin
                    nxt.dots = '0;
                    if (line_inc > LAST_LINE) begin
                        // frame wraps back to the top line
                        nxt.line  = '0;
                        nxt.mode  = MODE_OAM;
                        nxt.coinc = coinc_zero;
                        res.stat_irq = i_cfg.display_enable
                                     & (i_cfg.oam_irq_enable
                                        | (coinc_zero & i_cfg.coincidence_irq_enable));
                    end else begin
                        nxt.line  = line_inc;
                        nxt.coinc = coinc_inc;
                        res.stat_irq = coinc_inc & i_cfg.display_enable
                                     & i_cfg.coincidence_irq_enable;
                    end
                end
            end
            default: begin
                nxt = i_state;
            end
        endcase
        res.mode_now    = nxt.mode;
        res.line_now    = nxt.line;
        res.coincidence = nxt.coinc;
    end

    assign o_state  = nxt;
    assign o_result = res;

endmodule

FILE: rtl/core/lcd_mode_timing_sequencer.sv
// lcd_mode_timing_sequencer: top level with configuration registers,
// timing state and the result register. Depends on lcdt_pkg and lcdt_step.

// Each accepted item of elapsed CPU ticks advances the display timing by one
// step and yields exactly one result, registered in the cycle after acceptance.
// One item is taken every cycle: the timing state updates at acceptance and a
// single output register holds the result, so o_ready stays high unless a
// result is waiting and the consumer is stalling. The step itself is one add,
// a few compares and the mode update. Configuration registers are written
// through i_cfg_we with no wait; writes to indexes beyond the register list
// are ignored.
module lcd_mode_timing_sequencer
    import lcdt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_D_W-1:0] i_cfg_wdata,
    // input items
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [TICK_W-1:0]  i_tick_count,
    // result items
    output logic               o_valid,
    input  logic               i_ready,
    output logic [MODE_W-1:0]  o_mode_now,
    output logic [LINE_W-1:0]  o_line_now,
    output logic               o_coincidence,
    output logic               o_stat_irq,
    output logic               o_vblank_irq,
    output logic               o_frame_done,
    output logic               o_render_line,
    output logic [LINE_W-1:0]  o_rendered_index
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_acc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.compare_line           <= '0;
            r_cfg.display_enable         <= 1'b1;
            r_cfg.hblank_irq_enable      <= 1'b0;
            r_cfg.vblank_stat_enable     <= 1'b0;
            r_cfg.oam_irq_enable         <= 1'b0;
            r_cfg.coincidence_irq_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_COMPARE_LINE: r_cfg.compare_line           <= i_cfg_wdata;
                REG_DISPLAY_EN:   r_cfg.display_enable         <= i_cfg_wdata[0];
                REG_HBLANK_IE:    r_cfg.hblank_irq_enable      <= i_cfg_wdata[0];
                REG_VBLANK_IE:    r_cfg.vblank_stat_enable     <= i_cfg_wdata[0];
                REG_OAM_IE:       r_cfg.oam_irq_enable         <= i_cfg_wdata[0];
                REG_COINC_IE:     r_cfg.coincidence_irq_enable <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // step logic
    lcdt_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_tick_count (i_tick_count),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // handshake: take an item whenever the result register is free or draining
    assign o_ready = !r_out_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    // timing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode  <= MODE_OAM;
            r_state.line  <= '0;
            r_state.dots  <= '0;
            r_state.coinc <= 1'b0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mode_now       = r_result.mode_now;
    assign o_line_now       = r_result.line_now;
    assign o_coincidence    = r_result.coincidence;
    assign o_stat_irq       = r_result.stat_irq;
    assign o_vblank_irq     = r_result.vblank_irq;
    assign o_frame_done     = r_result.frame_done;
    assign o_render_line    = r_result.render_line;
    assign o_rendered_index = r_result.rendered_index;

`ifndef SYNTHESIS
    // line counter never leaves the frame
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line <= LAST_LINE)
        else $error("line counter beyond last line");

    // a mode change always restarts the dot count
    a_mode_clears_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_state.mode != r_state.mode) |=> (r_state.dots == '0))
        else $error("dot counter not cleared on mode change");

    // render strobe only on entry to horizontal blank
    a_render_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_render_line) |-> (o_mode_now == MODE_HBLANK))
        else $error("render strobe outside horizontal blank");

    // frame completion only at the first vertical blank line
    a_frame_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done)
            |-> (o_line_now == FIRST_VBLANK && o_mode_now == MODE_VBLANK && o_vblank_irq))
        else $error("frame done away from first vertical blank line");

    // rendered index is zero without a render strobe
    a_index_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_render_line) |-> (o_rendered_index == '0))
        else $error("rendered index set without strobe");
`endif

endmodule
